// File: hw/rtl/ssds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssds_pkg
// Shared constants and helpers for the decimal seven-segment scanner:
// reciprocal multipliers for the decimal weights and the segment table.
// ----------------------------------------------------------------------------
package ssds_pkg;

	localparam int unsigned ValueWidth  = 16;
	localparam int unsigned SegWidth    = 7;
	localparam int unsigned SelWidth    = 4;
	localparam int unsigned DigitWidth  = 4;
	localparam int unsigned RecipWidth  = 17;
	localparam int unsigned ShiftWidth  = 5;
	localparam int unsigned ProdWidth   = ValueWidth + RecipWidth;
	localparam int unsigned Q10Width    = 13;
	localparam int unsigned WeightCount = 6;
	localparam int unsigned WidxWidth   = 3;

	typedef logic [ValueWidth-1:0] value_t;
	typedef logic [RecipWidth-1:0] recip_t;
	typedef logic [ShiftWidth-1:0] shift_t;
	typedef logic [SegWidth-1:0]   seg_t;
	typedef logic [DigitWidth-1:0] digit_t;

	// floor(x / d) == (x * RecipMul) >> RecipShift, exact for any 16-bit x.
	// Entries follow the weights 1, 10, 100, 1000, 10000, 100000; the last
	// one gives zero for every 16-bit x.
	localparam recip_t RecipMul [0:WeightCount-1] = '{
		17'd65536, 17'd104858, 17'd83887, 17'd67109, 17'd107375, 17'd0
	};
	localparam shift_t RecipShift [0:WeightCount-1] = '{
		5'd16, 5'd20, 5'd23, 5'd26, 5'd30, 5'd16
	};

	// Segment pattern, bit0 = a ... bit6 = g. Seven keeps segment f lit.
	function automatic seg_t seg_pattern(input digit_t d);
		seg_t s;
		case (d)
			4'd0: s = 7'h3f;
			4'd1: s = 7'h06;
			4'd2: s = 7'h5b;
			4'd3: s = 7'h4f;
			4'd4: s = 7'h66;
			4'd5: s = 7'h6d;
			4'd6: s = 7'h7d;
			4'd7: s = 7'h27;
			4'd8: s = 7'h7f;
			4'd9: s = 7'h6f;
			default: s = 7'h00;
		endcase
		return s;
	endfunction

endpackage

// File: hw/rtl/ssds_scan_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssds_scan_ctrl
// Holds the hold-count register, the tick counter and the current digit
// position; advances the position once the hold count is used up.
// ----------------------------------------------------------------------------
module ssds_scan_ctrl #(
	parameter int unsigned DIGIT_COUNT = 4,
	parameter int unsigned PosWidth    = 2
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             tick,
	input  logic                             cfg_we,
	input  logic [ssds_pkg::ValueWidth-1:0]  cfg_wdata,
	output logic [PosWidth-1:0]              pos
);

	logic [ssds_pkg::ValueWidth-1:0] hold_ticks_q;
	logic [ssds_pkg::ValueWidth-1:0] cnt_q;
	logic [PosWidth-1:0]             pos_q;
	logic [ssds_pkg::ValueWidth:0]   cnt_next;
	logic [ssds_pkg::ValueWidth:0]   limit;
	logic                            wrap;

	// A zero hold count behaves as one.
	assign cnt_next = {1'b0, cnt_q} + 17'd1;
	assign limit    = (hold_ticks_q == '0) ? 17'd1 : {1'b0, hold_ticks_q};
	assign wrap     = (cnt_next >= limit);
	assign pos      = pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q <= 16'd750;
			cnt_q        <= '0;
			pos_q        <= '0;
		end else begin
			if (cfg_we) begin
				hold_ticks_q <= cfg_wdata;
			end
			if (tick) begin
				if (wrap) begin
					cnt_q <= '0;
					if (pos_q == PosWidth'(DIGIT_COUNT - 1)) begin
						pos_q <= '0;
					end else begin
						pos_q <= pos_q + PosWidth'(1);
					end
				end else begin
					cnt_q <= cnt_next[ssds_pkg::ValueWidth-1:0];
				end
			end
		end
	end

endmodule

// File: hw/rtl/seven_segment_decimal_scanner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_decimal_scanner_core
// Decimal digit scanner for a multiplexed seven-segment display.
// ----------------------------------------------------------------------------
// An item accepted at a rising edge sits in the input register; its result then
// moves into the result register and is offered on m_axis.
// Throughput: one item per cycle while the sink takes results; the digit is found
// by short logic between the input and the result register, so no gap is needed.
// A stalled sink holds two items (input and result register) before tready drops.
// Reset clears both valid bits, the digit position and the tick counter,
// and loads the hold count with 750.
// ----------------------------------------------------------------------------
module seven_segment_decimal_scanner_core #(
	parameter int unsigned DIGIT_COUNT = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input item: [15:0] display_value
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,
	// Result item: [6:0] segments, [10:7] digit_select, [14:11] digit_shown,
	// [15] zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,
	// Hold count register (ticks per digit)
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	localparam int unsigned PosWidth = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

	// ---------------------------------------------------------------- handshake
	logic ld_s1, ld_out;
	logic v_s1, out_valid_q;
	logic accept;

	// Each register takes new data when it is empty or its content moves on.
	assign ld_out        = !out_valid_q || m_axis_tready;
	assign ld_s1         = !v_s1 || ld_out;
	assign s_axis_tready = ld_s1;
	assign accept        = s_axis_tvalid && ld_s1;

	// ---------------------------------------------------------------- scan state
	logic [PosWidth-1:0] pos;

	ssds_scan_ctrl #(
		.DIGIT_COUNT (DIGIT_COUNT),
		.PosWidth    (PosWidth)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (accept),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pos       (pos)
	);

	// Select line of the current position; a fifth position has no line.
	logic [ssds_pkg::SelWidth-1:0] sel_d;
	assign sel_d = (32'(pos) < ssds_pkg::SelWidth) ?
		ssds_pkg::SelWidth'(4'b0001 << pos) : '0;

	// ---------------------------------------------------------------- stage 1
	// Capture the value together with the position it is shown at.
	ssds_pkg::value_t              value_s1;
	logic [PosWidth-1:0]           pos_s1;
	logic [ssds_pkg::SelWidth-1:0] sel_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ld_s1) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_s1 <= s_axis_tdata;
			pos_s1   <= pos;
			sel_s1   <= sel_d;
		end
	end

	// ---------------------------------------------------------------- result
	// The first position is the most significant digit. Divide by the weight
	// of this position and, in parallel, by ten times that weight; both are
	// reciprocal multiplies. The digit is then
	// quotient - 10 * (quotient by ten times the weight).
	logic [ssds_pkg::WidxWidth-1:0] widx;
	logic [ssds_pkg::WidxWidth-1:0] widx_hi;
	logic [ssds_pkg::ProdWidth-1:0] quot_prod;
	logic [ssds_pkg::ProdWidth-1:0] hi_prod;
	ssds_pkg::value_t               quot_d;
	logic [ssds_pkg::Q10Width-1:0]  quot_hi_d;
	ssds_pkg::value_t               times10;
	ssds_pkg::value_t               rem_full;
	ssds_pkg::digit_t               digit_d;
	ssds_pkg::seg_t                 seg_q;
	logic [ssds_pkg::SelWidth-1:0]  sel_q;
	ssds_pkg::digit_t               digit_q;

	assign widx      = ssds_pkg::WidxWidth'(DIGIT_COUNT - 1)
		- ssds_pkg::WidxWidth'(pos_s1);
	assign widx_hi   = widx + ssds_pkg::WidxWidth'(1);
	assign quot_prod = {{ssds_pkg::RecipWidth{1'b0}}, value_s1}
		* {{ssds_pkg::ValueWidth{1'b0}}, ssds_pkg::RecipMul[widx]};
	assign hi_prod   = {{ssds_pkg::RecipWidth{1'b0}}, value_s1}
		* {{ssds_pkg::ValueWidth{1'b0}}, ssds_pkg::RecipMul[widx_hi]};
	assign quot_d    = ssds_pkg::ValueWidth'(quot_prod >> ssds_pkg::RecipShift[widx]);
	assign quot_hi_d = ssds_pkg::Q10Width'(hi_prod >> ssds_pkg::RecipShift[widx_hi]);

	assign times10  = ssds_pkg::ValueWidth'({quot_hi_d, 3'b000})
		+ ssds_pkg::ValueWidth'({quot_hi_d, 1'b0});
	assign rem_full = quot_d - times10;
	assign digit_d  = rem_full[ssds_pkg::DigitWidth-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_out) begin
			out_valid_q <= v_s1;
		end
	end

	// Hold the result until the sink takes it.
	always_ff @(posedge clk) begin
		if (ld_out && v_s1) begin
			seg_q   <= ssds_pkg::seg_pattern(digit_d);
			sel_q   <= sel_s1;
			digit_q <= digit_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, digit_q, sel_q, seg_q};

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the decimal seven-segment scanner. Every accepted
// display tick is run through a local scan predictor; each result item is
// compared field by field with the oldest predicted scan output. Directed
// tests cover reset defaults, value extremes, a zero and a maximum hold count
// and a hold count lowered below the running count. Random phases follow,
// with random idling on both streams and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int unsigned DIGITS     = 4;
	localparam int unsigned SETTLE     = 8;        // pipeline latency plus margin
	localparam int unsigned LONG_HOLD  = 80;       // output hold-off, in cycles
	localparam int unsigned TIMEOUT_NS = 2000000;

	// Reset state of the hold count register.
	localparam logic [15:0] HOLD_RESET = 16'd750;

	typedef struct packed {
		ssds_pkg::seg_t   segments;
		logic [3:0]       digit_select;
		ssds_pkg::digit_t digit_shown;
	} scan_out_t;

	// Own copy of the segment patterns, bit0 = a ... bit6 = g.
	localparam ssds_pkg::seg_t SEG_LUT [0:9] = '{
		7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66, 7'h6d, 7'h7d, 7'h27, 7'h7f, 7'h6f
	};
	localparam int unsigned DIGIT_WEIGHT [0:4] = '{1, 10, 100, 1000, 10000};

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	// Predictor state: mirrors the scan position, tick counter and register.
	logic [15:0] scan_hold;
	int unsigned scan_pos;
	int unsigned scan_count;

	scan_out_t   pending_scan[$];

	// Idling controls shared between the tests and the two stream processes.
	bit          tx_gaps_on;
	bit          rx_gaps_on;
	bit          hold_off_req;

	int unsigned error_count;
	int unsigned ticks_sent;
	int unsigned results_seen;
	int unsigned hold_writes;

	seven_segment_decimal_scanner_core #(
		.DIGIT_COUNT(DIGITS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	// 4 ns clock.
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(15, 40);
	endfunction

	// Display values: full 16-bit range, in-range decimals, repeated digits
	// and the boundary values.
	function automatic ssds_pkg::value_t pick_value();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return ssds_pkg::value_t'($urandom);
		else if (r < 7)
			return ssds_pkg::value_t'($urandom_range(0, 9999));
		else if (r < 9)
			return ssds_pkg::value_t'($urandom_range(0, 9) * 1111);
		else begin
			case ($urandom_range(0, 3))
				0: return 16'd0;
				1: return 16'd9999;
				2: return 16'd10000;
				default: return 16'hffff;
			endcase
		end
	endfunction

	// Predict the output of one tick and advance the scan.
	task automatic advance_scan(input ssds_pkg::value_t v, output scan_out_t r);
		int unsigned pos;
		int unsigned widx;
		int unsigned digit;
		int unsigned limit;
		int unsigned val;
		val = 32'(v);
		pos = scan_pos;
		if (pos >= DIGITS)
			pos = 0;
		widx = (DIGITS - 1 - pos) % 5;
		digit = (val / DIGIT_WEIGHT[widx]) % 10;
		r.segments = SEG_LUT[digit];
		r.digit_select = (pos < 4) ? 4'(1 << pos) : 4'd0;
		r.digit_shown = ssds_pkg::digit_t'(digit);
		// A zero hold count behaves as one.
		limit = (scan_hold == 16'd0) ? 1 : int'(scan_hold);
		scan_count = scan_count + 1;
		if (scan_count >= limit) begin
			scan_count = 0;
			pos = pos + 1;
			if (pos >= DIGITS)
				pos = 0;
		end
		scan_pos = pos;
	endtask

	// Offer one tick item; call at a rising edge, return at the accepting edge.
	// tvalid is left high so back-to-back items need no second assignment.
	task automatic send_tick(input ssds_pkg::value_t v);
		int unsigned gap;
		scan_out_t   r;
		gap = tx_gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= v;
		// Inputs settle between edges: a handshake seen at the falling edge
		// happens at the next rising edge.
		do
			@(negedge clk);
		while (!s_axis_tready);
		advance_scan(v, r);
		pending_scan.push_back(r);
		ticks_sent++;
		@(posedge clk);
	endtask

	// Drop the input, wait for every predicted item, then let the pipe empty.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_scan.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write the hold count; only called with the block idle.
	task automatic write_hold(input logic [15:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		scan_hold = v;
		hold_writes++;
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	// Reset default: hold of 750, scan starts on the thousands digit.
	task automatic test_reset_defaults();
		send_tick(16'd1234);
		send_tick(16'd5678);
		send_tick(16'd9999);
		drain();
	endtask

	// Value extremes and every position with the fastest scan.
	task automatic test_value_extremes();
		write_hold(16'd1);
		send_tick(16'd0);
		send_tick(16'hffff);
		send_tick(16'd9999);
		send_tick(16'd10000);
		send_tick(16'd7777);
		send_tick(16'h8000);
		send_tick(16'd1234);
		send_tick(16'd5678);
		send_tick(16'd9012);
		send_tick(16'd3456);
		drain();
	endtask

	// Zero hold count acts as one: advance on every tick.
	task automatic test_zero_hold();
		write_hold(16'd0);
		repeat (4) send_tick(pick_value());
		drain();
	endtask

	// Lower the hold count below the running count: the next tick advances.
	task automatic test_hold_lowered();
		write_hold(16'd6);
		do
			send_tick(pick_value());
		while (scan_count < 4);
		drain();
		write_hold(16'd2);
		repeat (3) send_tick(pick_value());
		drain();
	endtask

	// Largest hold count.
	task automatic test_max_hold();
		write_hold(16'hffff);
		repeat (2) send_tick(pick_value());
		drain();
	endtask

	// Random phases, each with its own hold count and idling mix.
	task automatic test_random_scan(input int unsigned n_items);
		int unsigned per_phase;
		logic [15:0] h;
		per_phase = n_items / 6;
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: h = 16'd1;
				1: h = 16'd0;
				2: h = 16'd750;
				default: h = 16'($urandom_range(2, 12));
			endcase
			write_hold(h);
			tx_gaps_on = (p != 3);
			rx_gaps_on = (p != 4);
			repeat (per_phase) send_tick(pick_value());
			drain();
		end
		tx_gaps_on = 1'b1;
		rx_gaps_on = 1'b1;
	endtask

	// Hold the output off for a long stretch while ticks keep coming, so the
	// pipeline fills and stalls its input.
	task automatic test_output_stall();
		write_hold(16'd3);
		tx_gaps_on   = 1'b0;
		hold_off_req = 1'b1;
		repeat (40) send_tick(pick_value());
		drain();
		tx_gaps_on = 1'b1;
	endtask

	// Result side: drive tready at rising edges, with random stalls and the
	// long hold-off on request.
	initial begin
		int unsigned stall_left;
		stall_left    = 0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_left == 0) begin
				if (hold_off_req) begin
					hold_off_req = 1'b0;
					stall_left   = LONG_HOLD;
				end else if (rx_gaps_on) begin
					stall_left = pick_gap();
				end
			end
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Check each result item against the oldest prediction.
	always @(negedge clk) begin
		scan_out_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (pending_scan.size() == 0) begin
				$error("result item with no prediction: tdata %h", m_axis_tdata);
				error_count++;
			end else begin
				want = pending_scan.pop_front();
				if (m_axis_tdata[6:0] !== want.segments) begin
					$error("segments: expected %h, got %h", want.segments,
						m_axis_tdata[6:0]);
					error_count++;
				end
				if (m_axis_tdata[10:7] !== want.digit_select) begin
					$error("digit_select: expected %h, got %h", want.digit_select,
						m_axis_tdata[10:7]);
					error_count++;
				end
				if (m_axis_tdata[14:11] !== want.digit_shown) begin
					$error("digit_shown: expected %0d, got %0d", want.digit_shown,
						m_axis_tdata[14:11]);
					error_count++;
				end
				if (m_axis_tdata[15] !== 1'b0) begin
					$error("pad bit: expected 0, got %b", m_axis_tdata[15]);
					error_count++;
				end
			end
		end
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#(TIMEOUT_NS);
		$display("simulation failed");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 16'd0;
		cfg_we        = 1'b0;
		cfg_wdata     = 16'd0;
		tx_gaps_on    = 1'b1;
		rx_gaps_on    = 1'b1;
		hold_off_req  = 1'b0;
		error_count   = 0;
		ticks_sent    = 0;
		results_seen  = 0;
		hold_writes   = 0;
		scan_hold     = HOLD_RESET;
		scan_pos      = 0;
		scan_count    = 0;

		// Hold reset, then release it on a rising edge.
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_value_extremes();
		test_zero_hold();
		test_hold_lowered();
		test_max_hold();
		test_random_scan(900);
		test_output_stall();

		if (pending_scan.size() != 0) begin
			$error("%0d predicted items never arrived", pending_scan.size());
			error_count++;
		end

		$display("covered %0d display ticks, %0d result items checked, %0d hold writes",
			ticks_sent, results_seen, hold_writes);
		$display("hold counts 0, 1, small, 750 and 65535, a lowered hold and a long stall");
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
